// ===== rtl/vgm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgm_pkg
// Shared types and constants of the voxel grid map store: request codes,
// register indexes, operation classes and the job record that the front end
// hands to the back end.
// ----------------------------------------------------------------------------
package vgm_pkg;

	// request codes on the req_type field
	localparam logic [2:0] REQ_READ_CELL = 3'd0;
	localparam logic [2:0] REQ_WRITE_CELL = 3'd1;
	localparam logic [2:0] REQ_CMP_CELL = 3'd2;
	localparam logic [2:0] REQ_READ_POS = 3'd3;
	localparam logic [2:0] REQ_WRITE_POS = 3'd4;
	localparam logic [2:0] REQ_CMP_POS = 3'd5;
	localparam logic [2:0] REQ_CONVERT = 3'd6;

	// configuration register indexes
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 32;
	localparam logic [CFG_IW-1:0] CFG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_ORIGIN_Z = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_INV_RES_X = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_INV_RES_Y = 3'd4;
	localparam logic [CFG_IW-1:0] CFG_INV_RES_Z = 3'd5;

	localparam logic [23:0] INV_RES_RESET = 24'd655360;

	// saturation limits of a cell coordinate
	localparam logic [15:0] CELL_MAX = 16'h7fff;
	localparam logic [15:0] CELL_MIN = 16'h8000;

	// operation class of a request
	typedef enum logic [2:0] {
		OP_NOP,
		OP_READ,
		OP_WRITE,
		OP_CMP,
		OP_CONV
	} op_t;

	// classified request passed from front to back
	typedef struct packed {
		op_t op;
		logic hit;
		logic [7:0] label;
		logic [15:0] cx;
		logic [15:0] cy;
		logic [15:0] cz;
	} job_t;

endpackage

// ===== rtl/vgm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgm_req_if / vgm_rsp_if
// Valid/ready channels for requests into and results out of the map store.
// ----------------------------------------------------------------------------
interface vgm_req_if;
	logic valid;
	logic ready;
	logic [2:0] req_type;
	logic signed [15:0] cell_in_x;
	logic signed [15:0] cell_in_y;
	logic signed [15:0] cell_in_z;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic [7:0] label;

	modport source (
		output valid, req_type, cell_in_x, cell_in_y, cell_in_z,
		output pos_x, pos_y, pos_z, label,
		input ready
	);
	modport sink (
		input valid, req_type, cell_in_x, cell_in_y, cell_in_z,
		input pos_x, pos_y, pos_z, label,
		output ready
	);
endinterface

interface vgm_rsp_if;
	logic valid;
	logic ready;
	logic [7:0] read_label;
	logic hit;
	logic equal;
	logic signed [15:0] cell_out_x;
	logic signed [15:0] cell_out_y;
	logic signed [15:0] cell_out_z;

	modport source (
		output valid, read_label, hit, equal, cell_out_x, cell_out_y, cell_out_z,
		input ready
	);
	modport sink (
		input valid, read_label, hit, equal, cell_out_x, cell_out_y, cell_out_z,
		output ready
	);
endinterface

// ===== rtl/vgm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgm_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module vgm_ram #(
	parameter int WIDTH = 8,
	parameter longint DEPTH = 65536
) (
	input  logic clk,
	input  logic we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/vgm_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgm_fifo
// Short queue between the front end and the back end of the map store.
// ----------------------------------------------------------------------------
module vgm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [WIDTH-1:0] wdata,
	output logic full,
	input  logic pop,
	output logic [WIDTH-1:0] rdata,
	output logic empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] buf_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0] count_q;

	assign full = (count_q == (PW+1)'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = buf_q[rd_ptr_q];

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// store entries
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== rtl/vgm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgm_front
// Front end: holds the configuration, classifies requests, converts world
// positions to saturated cells, tests the grid range and forms the flat
// store index. Seven pipeline stages, one request per cycle while a full queue does not stall them.
// ----------------------------------------------------------------------------
module vgm_front
	import vgm_pkg::*;
#(
	parameter int SIZE_X = 64,
	parameter int SIZE_Y = 64,
	parameter int SIZE_Z = 16,
	parameter int AW = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	vgm_req_if.sink req,
	input  logic open_in,
	output logic push,
	output job_t job,
	output logic [AW-1:0] idx,
	input  logic full
);

	localparam int XW = (SIZE_X > 1) ? $clog2(SIZE_X) : 1;
	localparam int YW = (SIZE_Y > 1) ? $clog2(SIZE_Y) : 1;
	localparam int ZW = (SIZE_Z > 1) ? $clog2(SIZE_Z) : 1;

	logic [31:0] origin_q [3];
	logic [23:0] inv_res_q [3];

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	op_t op_s1, op_s2, op_s3, op_s4, op_s5, op_s6;
	logic pos_s1, pos_s2, pos_s3, pos_s4;
	logic [7:0] lbl_s1, lbl_s2, lbl_s3, lbl_s4, lbl_s5, lbl_s6;
	logic [15:0] cin_s1 [3];
	logic [15:0] cin_s2 [3];
	logic [15:0] cin_s3 [3];
	logic [15:0] cin_s4 [3];
	logic [32:0] diff_s1 [3];
	logic [32:0] mag_s2 [3];
	logic neg_s2 [3];
	logic neg_s3 [3];
	logic neg_s4 [3];
	logic [40:0] p0_s3 [3];
	logic [39:0] p1_s3 [3];
	logic [25:0] q_s4 [3];
	logic [15:0] cell_s5 [3];
	logic [15:0] cell_s6 [3];
	logic hit_s6;
	logic [AW-1:0] yz_s6;
	job_t job_s7;
	logic [AW-1:0] idx_s7;

	op_t op_in;
	logic pos_in;
	logic [31:0] pos_in_v [3];
	logic [15:0] cin_in [3];
	logic [57:0] sum [3];
	logic [15:0] cell_c [3];
	logic in_rng;

	function automatic logic axis_ok(input logic [15:0] c, input int size);
		axis_ok = !c[15] && (17'(c[14:0]) < 17'(size));
	endfunction

	// stall the whole pipe while the last stage waits on a full queue
	assign en = !v_s7 || !full;
	assign req.ready = en && open_in;
	assign push = v_s7 && !full;
	assign job = job_s7;
	assign idx = idx_s7;

	// classify request code
	always_comb begin
		case (req.req_type)
			REQ_READ_CELL, REQ_READ_POS: op_in = OP_READ;
			REQ_WRITE_CELL, REQ_WRITE_POS: op_in = OP_WRITE;
			REQ_CMP_CELL, REQ_CMP_POS: op_in = OP_CMP;
			REQ_CONVERT: op_in = OP_CONV;
			default: op_in = OP_NOP;
		endcase
		pos_in = (req.req_type == REQ_READ_POS) || (req.req_type == REQ_WRITE_POS) ||
			(req.req_type == REQ_CMP_POS) || (req.req_type == REQ_CONVERT);
		pos_in_v[0] = req.pos_x;
		pos_in_v[1] = req.pos_y;
		pos_in_v[2] = req.pos_z;
		cin_in[0] = req.cell_in_x;
		cin_in[1] = req.cell_in_y;
		cin_in[2] = req.cell_in_z;
	end

	// round half away from zero, then saturate
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			sum[a] = 58'(p0_s3[a]) + (58'(p1_s3[a]) << 17) + 58'(33'h080000000);
			if (op_s4 == OP_NOP) begin
				cell_c[a] = '0;
			end else if (!pos_s4) begin
				cell_c[a] = cin_s4[a];
			end else if (neg_s4[a]) begin
				cell_c[a] = (q_s4[a] > 26'd32768) ? CELL_MIN : 16'(16'd0 - q_s4[a][15:0]);
			end else begin
				cell_c[a] = (q_s4[a] > 26'd32767) ? CELL_MAX : q_s4[a][15:0];
			end
		end
		in_rng = (op_s5 != OP_NOP) && axis_ok(cell_s5[0], SIZE_X) &&
			axis_ok(cell_s5[1], SIZE_Y) && axis_ok(cell_s5[2], SIZE_Z);
	end

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				origin_q[a] <= '0;
				inv_res_q[a] <= INV_RES_RESET;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ORIGIN_X: origin_q[0] <= cfg_data;
				CFG_ORIGIN_Y: origin_q[1] <= cfg_data;
				CFG_ORIGIN_Z: origin_q[2] <= cfg_data;
				CFG_INV_RES_X: inv_res_q[0] <= cfg_data[23:0];
				CFG_INV_RES_Y: inv_res_q[1] <= cfg_data[23:0];
				CFG_INV_RES_Z: inv_res_q[2] <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= req.valid && req.ready;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (en) begin
			// s1: capture request, subtract origin at 33 bits
			op_s1 <= op_in;
			pos_s1 <= pos_in;
			lbl_s1 <= req.label;
			for (int a = 0; a < 3; a++) begin
				cin_s1[a] <= cin_in[a];
				diff_s1[a] <= {pos_in_v[a][31], pos_in_v[a]} -
					{origin_q[a][31], origin_q[a]};
			end
			// s2: magnitude and sign
			op_s2 <= op_s1;
			pos_s2 <= pos_s1;
			lbl_s2 <= lbl_s1;
			for (int a = 0; a < 3; a++) begin
				cin_s2[a] <= cin_s1[a];
				neg_s2[a] <= diff_s1[a][32];
				mag_s2[a] <= diff_s1[a][32] ? 33'd0 - diff_s1[a] : diff_s1[a];
			end
			// s3: partial products of magnitude and cells per meter
			op_s3 <= op_s2;
			pos_s3 <= pos_s2;
			lbl_s3 <= lbl_s2;
			for (int a = 0; a < 3; a++) begin
				cin_s3[a] <= cin_s2[a];
				neg_s3[a] <= neg_s2[a];
				p0_s3[a] <= 41'(mag_s2[a][16:0]) * 41'(inv_res_q[a]);
				p1_s3[a] <= 40'(mag_s2[a][32:17]) * 40'(inv_res_q[a]);
			end
			// s4: sum and round
			op_s4 <= op_s3;
			pos_s4 <= pos_s3;
			lbl_s4 <= lbl_s3;
			for (int a = 0; a < 3; a++) begin
				cin_s4[a] <= cin_s3[a];
				neg_s4[a] <= neg_s3[a];
				q_s4[a] <= sum[a][57:32];
			end
			// s5: select cell and saturate
			op_s5 <= op_s4;
			lbl_s5 <= lbl_s4;
			for (int a = 0; a < 3; a++) begin
				cell_s5[a] <= cell_c[a];
			end
			// s6: range test and row-plane index
			op_s6 <= op_s5;
			lbl_s6 <= lbl_s5;
			for (int a = 0; a < 3; a++) begin
				cell_s6[a] <= cell_s5[a];
			end
			hit_s6 <= in_rng;
			yz_s6 <= AW'(cell_s5[1][YW-1:0]) + AW'(SIZE_Y) * AW'(cell_s5[2][ZW-1:0]);
			// s7: flat index
			job_s7.op <= op_s6;
			job_s7.hit <= hit_s6;
			job_s7.label <= lbl_s6;
			job_s7.cx <= cell_s6[0];
			job_s7.cy <= cell_s6[1];
			job_s7.cz <= cell_s6[2];
			idx_s7 <= AW'(cell_s6[0][XW-1:0]) + AW'(SIZE_X) * yz_s6;
		end
	end

endmodule

// ===== rtl/vgm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgm_back
// Back end: clears the cell store after reset, then carries out queued jobs
// against the store in order and holds each result in an output register.
// ----------------------------------------------------------------------------
module vgm_back
	import vgm_pkg::*;
#(
	parameter longint DEPTH = 65536,
	parameter int AW = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  job_t job,
	input  logic [AW-1:0] idx,
	input  logic empty,
	output logic pop,
	output logic open_in,
	vgm_rsp_if.source rsp
);

	logic clr_busy_q;
	logic [AW-1:0] clr_addr_q;
	logic s1_v_q;
	job_t job_s1;
	logic out_v_q;
	logic [7:0] rd_q;
	logic hit_q;
	logic eq_q;
	logic [15:0] cx_q, cy_q, cz_q;

	logic adv;
	logic we;
	logic [AW-1:0] waddr;
	logic [7:0] wdata;
	logic re;
	logic [7:0] rdata;
	logic rd_op;

	assign open_in = !clr_busy_q;
	assign adv = !out_v_q || rsp.ready;
	assign pop = !empty && !clr_busy_q && (!s1_v_q || adv);

	// store access: clearing sweep first, then writes and reads of jobs
	assign we = clr_busy_q || (pop && job.hit && (job.op == OP_WRITE));
	assign waddr = clr_busy_q ? clr_addr_q : idx;
	assign wdata = clr_busy_q ? 8'd0 : job.label;
	assign re = pop && job.hit && ((job.op == OP_READ) || (job.op == OP_CMP));
	assign rd_op = job_s1.hit && ((job_s1.op == OP_READ) || (job_s1.op == OP_CMP));

	vgm_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_store (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.re(re),
		.raddr(idx),
		.rdata(rdata)
	);

	// sweep the store to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// hold access stage and result valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (pop) begin
				s1_v_q <= 1'b1;
			end else if (adv) begin
				s1_v_q <= 1'b0;
			end
			if (s1_v_q && adv) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// capture job and form result
	always_ff @(posedge clk) begin
		if (pop) begin
			job_s1 <= job;
		end
		if (s1_v_q && adv) begin
			rd_q <= rd_op ? rdata : 8'd0;
			eq_q <= job_s1.hit && (job_s1.op == OP_CMP) && (rdata == job_s1.label);
			hit_q <= job_s1.hit;
			cx_q <= job_s1.cx;
			cy_q <= job_s1.cy;
			cz_q <= job_s1.cz;
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.read_label = rd_q;
	assign rsp.hit = hit_q;
	assign rsp.equal = eq_q;
	assign rsp.cell_out_x = cx_q;
	assign rsp.cell_out_y = cy_q;
	assign rsp.cell_out_z = cz_q;

endmodule

// ===== rtl/voxel_grid_map_store_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_grid_map_store_top
// Three-dimensional store of 8-bit cell labels, x fastest, addressed by cell
// coordinate or by world position.
// ----------------------------------------------------------------------------
// After reset the block sweeps the store to zero, one cell per cycle, and
// req.ready stays low until the sweep is done; configuration writes are
// taken during the sweep. From then on one request is accepted per cycle
// unless a full queue stalls the front end, and every request gives exactly
// one result, in order. In the front end a request passes the origin
// subtract, magnitude, split 33x24 multiply, rounding add, saturation, range
// test and index stages, then the queue, then the back end's store read and
// result register. The single write and read port of the store sets the
// rate of one request a cycle.
// ----------------------------------------------------------------------------
module voxel_grid_map_store_top
	import vgm_pkg::*;
#(
	parameter int SIZE_X = 64,
	parameter int SIZE_Y = 64,
	parameter int SIZE_Z = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	vgm_req_if.sink req,
	vgm_rsp_if.source rsp
);

	localparam longint DEPTH = longint'(SIZE_X) * longint'(SIZE_Y) * longint'(SIZE_Z);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int QW = AW + $bits(job_t);

	logic open_in;
	logic push;
	job_t job_f;
	logic [AW-1:0] idx_f;
	logic full;
	logic pop;
	logic empty;
	logic [QW-1:0] q_rdata;
	job_t job_b;
	logic [AW-1:0] idx_b;

	assign {idx_b, job_b} = q_rdata;

	vgm_front #(
		.SIZE_X(SIZE_X),
		.SIZE_Y(SIZE_Y),
		.SIZE_Z(SIZE_Z),
		.AW(AW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req),
		.open_in(open_in),
		.push(push),
		.job(job_f),
		.idx(idx_f),
		.full(full)
	);

	vgm_fifo #(
		.WIDTH(QW),
		.DEPTH(4)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata({idx_f, job_f}),
		.full(full),
		.pop(pop),
		.rdata(q_rdata),
		.empty(empty)
	);

	vgm_back #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job(job_b),
		.idx(idx_b),
		.empty(empty),
		.pop(pop),
		.open_in(open_in),
		.rsp(rsp)
	);

endmodule
